@@ rtl/pfru_pkg.sv @@
// ----------------------------------------------------------------------------
// pfru_pkg: shared types and constants of the page frame replacement unit
// Sizes, event and status codes, the page map port bundle and the LFSR step.
// ----------------------------------------------------------------------------
package pfru_pkg;

  localparam int FRAME_SLOTS = 16;
  localparam int MAX_PROCS   = 8;
  localparam int MAX_PAGES   = 64;
  localparam int AGE_BITS    = 16;

  localparam int FRAME_W = $clog2(FRAME_SLOTS);
  localparam int PROC_W  = $clog2(MAX_PROCS);
  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int MAP_W   = $clog2(FRAME_SLOTS + 1);
  localparam int ADDR_W  = PROC_W + PAGE_W;
  localparam int FCNT_W  = 5;
  localparam int SIZE_W  = 7;
  localparam int CNT_W   = 7;
  localparam int LFSR_W  = 16;
  localparam int STEP_W  = $clog2(LFSR_W);
  localparam int PAGE_MAP_DEPTH = MAX_PROCS * MAX_PAGES;

  localparam logic [LFSR_W-1:0]   SEED_DEFAULT = 16'hACE1;
  localparam logic [LFSR_W-1:0]   LFSR_MASK    = 16'hB400;
  localparam logic [AGE_BITS-1:0] AGE_MAX      = {AGE_BITS{1'b1}};

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_REF    = 2'd1;
  localparam logic [1:0] FUNC_TERM   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] POL_RANDOM     = 2'd0;
  localparam logic [1:0] POL_LRU        = 2'd1;
  localparam logic [1:0] POL_FIFO       = 2'd2;
  localparam logic [1:0] POL_RANDOM_ALT = 2'd3;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_FRAMES = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [2:0] ST_IGNORED   = 3'd0;
  localparam logic [2:0] ST_HIT       = 3'd1;
  localparam logic [2:0] ST_FREE      = 3'd2;
  localparam logic [2:0] ST_EVICT     = 3'd3;
  localparam logic [2:0] ST_PROC_DONE = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_REF_CHK, S_FREE_SCAN, S_LRU_SCAN, S_RAND_WAIT,
    S_VICT, S_UNMAP, S_LOAD, S_TERM, S_FIFO_CMP, S_DONE
  } pfru_state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MAP_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } pfru_ram_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PROC_W-1:0]  pid;
  } pfru_fifo_ent_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_MASK;
    if (n == '0) n = SEED_DEFAULT;
    return n;
  endfunction

endpackage

@@ rtl/pfru_page_ram.sv @@
// ----------------------------------------------------------------------------
// pfru_page_ram: page map storage
// One entry per process and page, holding the frame number plus one.
// ----------------------------------------------------------------------------
module pfru_page_ram import pfru_pkg::*; (
  input  logic             clk_i,
  input  pfru_ram_req_t    req_i,
  output logic [MAP_W-1:0] rd_data_o
);

  logic [MAP_W-1:0] mem_q [PAGE_MAP_DEPTH];
  logic [MAP_W-1:0] rd_data_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
    rd_data_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/pfru_mod_unit.sv @@
// ----------------------------------------------------------------------------
// pfru_mod_unit: serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module pfru_mod_unit import pfru_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [FCNT_W-1:0] divisor_i,
  output logic              done_o,
  output logic [FCNT_W-1:0] rem_o
);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [LFSR_W-1:0] num_q, num_d;
  logic [FCNT_W-1:0] rem_q, rem_d;
  logic [FCNT_W-1:0] div_q, div_d;
  logic [FCNT_W:0]   trial;

  always_comb begin
    trial = {rem_q, num_q[LFSR_W-1]};
    if (trial >= {1'b0, div_q}) trial = trial - {1'b0, div_q};
  end

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    num_d    = num_q;
    rem_d    = rem_q;
    div_d    = div_q;
    if (start_i) begin
      active_d = 1'b1;
      step_d   = '0;
      num_d    = dividend_i;
      rem_d    = '0;
      div_d    = divisor_i;
    end else if (active_q) begin
      num_d  = num_q << 1;
      rem_d  = trial[FCNT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(LFSR_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/page_frame_replacement_unit_core.sv @@
// ----------------------------------------------------------------------------
// page_frame_replacement_unit_core: demand-paging frame manager
// Page tables, frame table, load-order queue and counters under a sequencer.
// ----------------------------------------------------------------------------
// Work per event: a process start clears its page map; a terminate walks the
// page map and compacts the load-order queue; a fault scans the frames for a
// free one, else picks a victim (frame scan, serial remainder or queue head)
// and walks the owner's page map to unmap it before the load.
// One event at a time; busy drops the cycle after the strobe. The receiver
// cannot stall. Reset clears all control state; the page map needs no clear.
// ----------------------------------------------------------------------------
module page_frame_replacement_unit_core import pfru_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    func_i,
  input  logic [2:0]    proc_id_i,
  input  logic [6:0]    page_index_i,
  input  logic [6:0]    page_count_i,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic [3:0]    frame_index_o,
  output logic [31:0]   fault_total_o,
  output logic [31:0]   reference_total_o
);

  pfru_state_e state_q, state_d;

  logic [1:0]          policy_q, policy_d;
  logic [FCNT_W-1:0]   fiu_q, fiu_d;
  logic [LFSR_W-1:0]   lfsr_q, lfsr_d;
  logic [31:0]         fault_q, fault_d;
  logic [31:0]         ref_q, ref_d;
  logic                live_q [MAX_PROCS];
  logic                live_d [MAX_PROCS];
  logic [SIZE_W-1:0]   size_q [MAX_PROCS];
  logic [SIZE_W-1:0]   size_d [MAX_PROCS];
  logic                valid_q [FRAME_SLOTS];
  logic                valid_d [FRAME_SLOTS];
  logic [PROC_W-1:0]   owner_q [FRAME_SLOTS];
  logic [PROC_W-1:0]   owner_d [FRAME_SLOTS];
  logic [AGE_BITS-1:0] age_q [FRAME_SLOTS];
  logic [AGE_BITS-1:0] age_d [FRAME_SLOTS];
  pfru_fifo_ent_t      fifo_q [FRAME_SLOTS];
  pfru_fifo_ent_t      fifo_d [FRAME_SLOTS];
  logic [FCNT_W-1:0]   fcount_q, fcount_d;
  logic [FCNT_W-1:0]   k_q, k_d;

  logic [1:0]          func_q, func_d;
  logic [PROC_W-1:0]   pid_q, pid_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                chk_q, chk_d;
  logic [PAGE_W-1:0]   chk_idx_q, chk_idx_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [AGE_BITS-1:0] best_q, best_d;
  logic [2:0]          status_q, status_d;

  pfru_ram_req_t       ram_req;
  logic [MAP_W-1:0]    ram_rd;
  logic                mod_start, mod_done;
  logic [FCNT_W-1:0]   mod_rem;
  logic [LFSR_W-1:0]   lfsr_nxt;

  logic                accept, in_live, ref_ok, hit, scan_in, unmap_issue, unmap_match;
  logic [FRAME_W-1:0]  scan_idx;
  logic [PROC_W-1:0]   unmap_owner;
  logic [SIZE_W-1:0]   in_size;

  pfru_page_ram u_page_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

  pfru_mod_unit u_mod_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lfsr_nxt),
    .divisor_i  (fiu_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign accept      = start_i && (state_q == S_IDLE);
  assign in_live     = live_q[proc_id_i];
  assign in_size     = size_q[proc_id_i];
  assign ref_ok      = in_live && (page_index_i != '0) && (page_index_i <= in_size) &&
                       (page_index_i <= SIZE_W'(MAX_PAGES));
  assign hit         = (ram_rd != '0) && (ram_rd <= MAP_W'(FRAME_SLOTS));
  assign scan_idx    = cnt_q[FRAME_W-1:0];
  assign scan_in     = cnt_q < {{(CNT_W - FCNT_W){1'b0}}, fiu_q};
  assign unmap_owner = owner_q[frame_q];
  assign unmap_issue = cnt_q < size_q[unmap_owner];
  assign unmap_match = chk_q && (ram_rd == MAP_W'({1'b0, frame_q} + 1'b1));
  assign lfsr_nxt    = lfsr_step(lfsr_q);
  assign mod_start   = (state_q == S_FREE_SCAN) && !scan_in &&
                       (policy_q != POL_LRU) && (policy_q != POL_FIFO);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (func_i)
            FUNC_START: state_d = in_live ? S_DONE : S_CLR;
            FUNC_REF:   state_d = ref_ok ? S_REF_CHK : S_DONE;
            FUNC_TERM:  state_d = in_live ? S_TERM : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_CLR:       if (cnt_q == CNT_W'(MAX_PAGES - 1)) state_d = S_DONE;
      S_REF_CHK:   state_d = hit ? S_DONE : S_FREE_SCAN;
      S_FREE_SCAN: begin
        if (scan_in) begin
          if (!valid_q[scan_idx]) state_d = S_LOAD;
        end else if (policy_q == POL_LRU) begin
          state_d = S_LRU_SCAN;
        end else if (policy_q == POL_FIFO) begin
          state_d = S_VICT;
        end else begin
          state_d = S_RAND_WAIT;
        end
      end
      S_LRU_SCAN:  if (!scan_in) state_d = S_VICT;
      S_RAND_WAIT: if (mod_done) state_d = S_VICT;
      S_VICT:      state_d = valid_q[frame_q] ? S_UNMAP : S_LOAD;
      S_UNMAP:     if (unmap_match || (!chk_q && !unmap_issue)) state_d = S_LOAD;
      S_LOAD:      state_d = S_DONE;
      S_TERM:      if (cnt_q == CNT_W'(MAX_PAGES)) state_d = S_FIFO_CMP;
      S_FIFO_CMP:  if (cnt_q >= {{(CNT_W - FCNT_W){1'b0}}, fcount_q}) state_d = S_DONE;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath and page map requests.
  always_comb begin
    logic               touch_en;
    logic [FRAME_W-1:0] touch_f;
    logic [FRAME_W-1:0] vf;
    logic [FRAME_W-1:0] tf;
    logic [4:0]         cv;
    pfru_fifo_ent_t     ent;

    touch_en = 1'b0;
    touch_f  = '0;
    vf       = '0;
    tf       = '0;
    cv       = '0;
    ent      = '0;

    policy_d  = policy_q;
    fiu_d     = fiu_q;
    lfsr_d    = lfsr_q;
    fault_d   = fault_q;
    ref_d     = ref_q;
    live_d    = live_q;
    size_d    = size_q;
    valid_d   = valid_q;
    owner_d   = owner_q;
    age_d     = age_q;
    fifo_d    = fifo_q;
    fcount_d  = fcount_q;
    k_d       = k_q;
    func_d    = func_q;
    pid_d     = pid_q;
    page_d    = page_q;
    cnt_d     = cnt_q;
    chk_d     = chk_q;
    chk_idx_d = chk_idx_q;
    frame_d   = frame_q;
    best_d    = best_q;
    status_d  = status_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = {pid_q, cnt_q[PAGE_W-1:0]};
    ram_req.wdata = '0;
    ram_req.raddr = {proc_id_i, PAGE_W'(page_index_i - 1'b1)};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d   = func_i;
          pid_d    = proc_id_i;
          page_d   = PAGE_W'(page_index_i - 1'b1);
          cnt_d    = '0;
          chk_d    = 1'b0;
          frame_d  = '0;
          status_d = ST_IGNORED;
          case (func_i)
            FUNC_START: begin
              if (!in_live) begin
                live_d[proc_id_i] = 1'b1;
                size_d[proc_id_i] = (page_count_i > SIZE_W'(MAX_PAGES)) ?
                                    SIZE_W'(MAX_PAGES) : page_count_i;
                status_d = ST_PROC_DONE;
              end
            end
            FUNC_REF:  ref_d = ref_q + 32'd1;
            FUNC_TERM: if (in_live) status_d = ST_PROC_DONE;
            default:   status_d = ST_IGNORED;
          endcase
        end
      end
      S_CLR: begin
        ram_req.we = 1'b1;
        cnt_d      = cnt_q + 1'b1;
      end
      S_REF_CHK: begin
        if (hit) begin
          frame_d  = FRAME_W'(ram_rd - 1'b1);
          status_d = ST_HIT;
          touch_en = (policy_q == POL_LRU);
          touch_f  = FRAME_W'(ram_rd - 1'b1);
        end else begin
          fault_d = fault_q + 32'd1;
          cnt_d   = '0;
        end
      end
      S_FREE_SCAN: begin
        if (scan_in) begin
          if (!valid_q[scan_idx]) begin
            frame_d  = scan_idx;
            status_d = ST_FREE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          status_d = ST_EVICT;
          cnt_d    = '0;
          best_d   = '0;
          frame_d  = '0;
          if (policy_q == POL_FIFO) begin
            if (fcount_q != '0) begin
              vf = fifo_q[0].frame;
              for (int i = 0; i < FRAME_SLOTS - 1; i++) fifo_d[i] = fifo_q[i + 1];
              fcount_d = fcount_q - 1'b1;
              if ({1'b0, vf} >= fiu_q) vf = '0;
            end
            frame_d = vf;
          end else if (policy_q != POL_LRU) begin
            lfsr_d = lfsr_nxt;
          end
        end
      end
      S_LRU_SCAN: begin
        if (scan_in) begin
          if (age_q[scan_idx] > best_q) begin
            best_d  = age_q[scan_idx];
            frame_d = scan_idx;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RAND_WAIT: if (mod_done) frame_d = mod_rem[FRAME_W-1:0];
      S_VICT: begin
        cnt_d = '0;
        chk_d = 1'b0;
      end
      S_UNMAP: begin
        // Reads stream one entry per cycle; each is checked when its data returns.
        ram_req.raddr = {unmap_owner, cnt_q[PAGE_W-1:0]};
        chk_d         = unmap_issue;
        chk_idx_d     = cnt_q[PAGE_W-1:0];
        if (unmap_issue) cnt_d = cnt_q + 1'b1;
        if (unmap_match) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = {unmap_owner, chk_idx_q};
        end
      end
      S_LOAD: begin
        valid_d[frame_q] = 1'b1;
        owner_d[frame_q] = pid_q;
        ram_req.we       = 1'b1;
        ram_req.waddr    = {pid_q, page_q};
        ram_req.wdata    = MAP_W'({1'b0, frame_q} + 1'b1);
        if (policy_q == POL_FIFO) begin
          ent.frame = frame_q;
          ent.pid   = pid_q;
          if (fcount_q >= FCNT_W'(FRAME_SLOTS)) begin
            for (int i = 0; i < FRAME_SLOTS - 1; i++) fifo_d[i] = fifo_q[i + 1];
            fifo_d[FRAME_SLOTS - 1] = ent;
          end else begin
            fifo_d[fcount_q[FRAME_W-1:0]] = ent;
            fcount_d = fcount_q + 1'b1;
          end
        end else if (policy_q == POL_LRU) begin
          touch_en = 1'b1;
          touch_f  = frame_q;
        end
      end
      S_TERM: begin
        if (cnt_q < CNT_W'(MAX_PAGES)) begin
          ram_req.raddr = {pid_q, cnt_q[PAGE_W-1:0]};
          ram_req.we    = 1'b1;
          cnt_d         = cnt_q + 1'b1;
          chk_d         = 1'b1;
        end else begin
          cnt_d = '0;
          chk_d = 1'b0;
          k_d   = '0;
        end
        if (chk_q && hit) begin
          tf          = FRAME_W'(ram_rd - 1'b1);
          valid_d[tf] = 1'b0;
          owner_d[tf] = '0;
          age_d[tf]   = '0;
        end
      end
      S_FIFO_CMP: begin
        // Compact the queue in place, keeping entries of other processes.
        if (cnt_q < {{(CNT_W - FCNT_W){1'b0}}, fcount_q}) begin
          ent = fifo_q[scan_idx];
          if (ent.pid != pid_q) begin
            fifo_d[k_q[FRAME_W-1:0]] = ent;
            k_d = k_q + 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
        end else begin
          fcount_d      = k_q;
          live_d[pid_q] = 1'b0;
          size_d[pid_q] = '0;
        end
      end
      default: begin
      end
    endcase

    if (touch_en) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        if (FCNT_W'(i) < fiu_q) begin
          if (FRAME_W'(i) == touch_f) age_d[i] = '0;
          else if (age_q[i] < AGE_MAX) age_d[i] = age_q[i] + 1'b1;
        end
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY: policy_d = cfg_data_i[1:0];
        CFG_FRAMES: begin
          cv = cfg_data_i[4:0];
          if (cv == '0) cv = 5'd1;
          if (cv > FCNT_W'(FRAME_SLOTS)) cv = FCNT_W'(FRAME_SLOTS);
          fiu_d = cv;
        end
        CFG_SEED:   lfsr_d = (cfg_data_i == '0) ? SEED_DEFAULT : cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      policy_q <= POL_LRU;
      fiu_q    <= FCNT_W'(FRAME_SLOTS);
      lfsr_q   <= SEED_DEFAULT;
      fault_q  <= '0;
      ref_q    <= '0;
      fcount_q <= '0;
      cnt_q    <= '0;
      chk_q    <= 1'b0;
      k_q      <= '0;
      status_q <= ST_IGNORED;
      for (int i = 0; i < MAX_PROCS; i++) begin
        live_q[i] <= 1'b0;
        size_q[i] <= '0;
      end
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        valid_q[i] <= 1'b0;
        owner_q[i] <= '0;
        age_q[i]   <= '0;
      end
    end else begin
      state_q  <= state_d;
      policy_q <= policy_d;
      fiu_q    <= fiu_d;
      lfsr_q   <= lfsr_d;
      fault_q  <= fault_d;
      ref_q    <= ref_d;
      fcount_q <= fcount_d;
      cnt_q    <= cnt_d;
      chk_q    <= chk_d;
      k_q      <= k_d;
      status_q <= status_d;
      live_q   <= live_d;
      size_q   <= size_d;
      valid_q  <= valid_d;
      owner_q  <= owner_d;
      age_q    <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q    <= fifo_d;
    func_q    <= func_d;
    pid_q     <= pid_d;
    page_q    <= page_d;
    chk_idx_q <= chk_idx_d;
    frame_q   <= frame_d;
    best_q    <= best_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign status_o          = status_q;
  assign frame_index_o     = (status_q == ST_HIT || status_q == ST_FREE ||
                              status_q == ST_EVICT) ? frame_q : '0;
  assign fault_total_o     = fault_q;
  assign reference_total_o = ref_q;

  // A frame result (hit, free frame or eviction) can only follow a reference event.
  a_status_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_HIT || status_o == ST_FREE || status_o == ST_EVICT))
      |-> (func_q == FUNC_REF))
    else $error("frame result for a non-reference event");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after an accepted event");

  a_ref_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_REF) |=> (ref_q == $past(ref_q) + 32'd1))
    else $error("reference counter did not advance");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= FCNT_W'(FRAME_SLOTS))
    else $error("frame queue count out of range");

endmodule
